// ===== sv/ctbs_pkg.sv =====
package ctbs_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_MAX_DELIMITER = 16;
    localparam int DEF_LENGTH_BITS   = 16;

    // result queue between the scan step and the output port
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // character codes
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DQUOTE     = 8'h22;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_SQUOTE     = 8'h27;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_DIGIT_0    = 8'h30;
    localparam logic [7:0] CH_DIGIT_9    = 8'h39;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_R    = 8'h52;
    localparam logic [7:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [7:0] CH_BSLASH     = 8'h5C;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_Z    = 8'h7A;

    typedef enum logic [3:0] {
        KIND_SPACE  = 4'd0,
        KIND_LINE   = 4'd1,
        KIND_BLOCK  = 4'd2,
        KIND_PP     = 4'd3,
        KIND_RAW    = 4'd4,
        KIND_IDENT  = 4'd5,
        KIND_NUMBER = 4'd6,
        KIND_STRING = 4'd7,
        KIND_CHAR   = 4'd8,
        KIND_OTHER  = 4'd9
    } t_kind;

    typedef enum logic [3:0] {
        MODE_IDLE,
        MODE_SPACE,
        MODE_LINE,
        MODE_BLOCK,
        MODE_BLOCK_STAR,
        MODE_PP,
        MODE_PP_BS,
        MODE_PP_BS_CR,
        MODE_RAW_DELIM,
        MODE_RAW_BODY,
        MODE_RAW_MATCH,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_STRING,
        MODE_CHAR
    } t_mode;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] length;
        logic        closed;
        logic        final_token;
    } t_token;

    // up to two tokens come out of one byte, slot 0 first
    typedef struct packed {
        logic [1:0]         vld;
        t_token [1:0]       tok;
    } t_step_out;

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
               (c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c == CH_UNDERSCORE);
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic is_cont(logic [7:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    function automatic logic is_ws(logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
    endfunction

endpackage

// ===== sv/c_token_boundary_scanner_core.sv =====
// path: a byte taken into the input register is scanned from there once the queue has room;
// its tokens are written into the result queue, which drives the output
// throughput: one byte per cycle when not stalled; a byte can yield two tokens while the output side
// moves one token per cycle while i_stall is low, so input stalls when the queue holds more than two
// reset: i_rst_n synchronous active low, clears scan state and queue; the raw-string
// delimiter store is not cleared and is only read after being written
module c_token_boundary_scanner_core #(
    parameter int MAX_DELIMITER = ctbs_pkg::DEF_MAX_DELIMITER,
    parameter int LENGTH_BITS   = ctbs_pkg::DEF_LENGTH_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // byte input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_text,
    // token output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [3:0]  o_token_kind,
    output logic [15:0] o_token_length,
    output logic        o_closed,
    output logic        o_final_token
);

    // input register
    logic                           r_in_vld;
    logic [7:0]                     r_in_byte;
    logic                           r_in_eot;

    // scan step and queue
    logic                           fire;
    logic                           pop;
    ctbs_pkg::t_step_out            step_res;
    ctbs_pkg::t_token               head;
    logic [ctbs_pkg::Q_CNT_W-1:0]   q_count;

    // a held byte is scanned once the queue has room for two tokens
    assign fire    = r_in_vld && (q_count <= ctbs_pkg::Q_CNT_W'(ctbs_pkg::Q_DEPTH - 2));
    // the input register refills in the same cycle its byte is scanned
    assign o_stall = r_in_vld && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_stall) begin
            r_in_vld <= i_valid;
        end
    end

    // payload beat, held while stalled
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_text_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    // mode decode, length count, delimiter match and flush for one byte
    ctbs_step #(
        .MAX_DELIMITER (MAX_DELIMITER),
        .LENGTH_BITS   (LENGTH_BITS)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .i_eot   (r_in_eot),
        .o_res   (step_res)
    );

    // result queue, doubles as the output register
    ctbs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (step_res),
        .i_pop   (pop),
        .o_head  (head),
        .o_count (q_count)
    );

    assign o_valid        = (q_count != '0);
    assign pop            = o_valid && !i_stall;
    assign o_token_kind   = head.kind;
    assign o_token_length = head.length;
    assign o_closed       = head.closed;
    assign o_final_token  = head.final_token;

endmodule

// ===== sv/ctbs_step.sv =====
module ctbs_step #(
    parameter int MAX_DELIMITER = ctbs_pkg::DEF_MAX_DELIMITER,
    parameter int LENGTH_BITS   = ctbs_pkg::DEF_LENGTH_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    input  logic                  i_eot,
    output ctbs_pkg::t_step_out   o_res
);

    localparam int DLW = $clog2(MAX_DELIMITER + 1);
    localparam int AW  = (MAX_DELIMITER > 1) ? $clog2(MAX_DELIMITER) : 1;

    ctbs_pkg::t_mode          r_mode, n_mode;
    logic                     r_la, n_la;
    logic [LENGTH_BITS-1:0]   r_len, n_len;
    logic                     r_esc, n_esc;
    logic [DLW-1:0]           r_match, n_match;
    logic [DLW-1:0]           r_dlen, n_dlen;
    logic                     r_als, n_als;

    // delimiter store, read one entry ahead of use
    logic [7:0]               r_dlm [MAX_DELIMITER];
    logic [7:0]               r_dlm_q;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;

    logic                     p_grow, p_emit, p_closed, p_start, p_body;
    ctbs_pkg::t_kind          p_kind;
    logic                     f_emit;
    ctbs_pkg::t_kind          f_kind;
    logic [1:0]               n_cnt;
    ctbs_pkg::t_step_out      n_res;

    function automatic ctbs_pkg::t_token mk_tok(ctbs_pkg::t_kind kind,
                                                logic [LENGTH_BITS-1:0] len,
                                                logic closed);
        ctbs_pkg::t_token       t;
        logic [LENGTH_BITS+15:0] wide;
        wide          = {16'b0, len};
        t.kind        = kind;
        t.length      = wide[15:0];
        t.closed      = closed;
        t.final_token = 1'b0;
        return t;
    endfunction

    always_comb begin
        n_mode  = r_mode;
        n_la    = r_la;
        n_len   = r_len;
        n_esc   = r_esc;
        n_match = r_match;
        n_dlen  = r_dlen;
        n_als   = r_als;
        wr_en   = 1'b0;
        wr_addr = r_dlen[AW-1:0];
        p_grow  = 1'b0;
        p_emit  = 1'b0;
        p_closed = 1'b0;
        p_start = 1'b0;
        p_body  = 1'b0;
        p_kind  = ctbs_pkg::KIND_OTHER;
        f_emit  = 1'b0;
        f_kind  = ctbs_pkg::KIND_OTHER;
        n_cnt   = 2'd0;
        n_res   = '0;

        if (i_fire) begin
            unique case (r_mode)
                ctbs_pkg::MODE_IDLE: begin
                    if (r_la) begin
                        n_la = 1'b0;
                        if (i_byte == ctbs_pkg::CH_SLASH) begin
                            n_mode = ctbs_pkg::MODE_LINE;
                            p_grow = 1'b1;
                        end else if (i_byte == ctbs_pkg::CH_STAR) begin
                            n_mode = ctbs_pkg::MODE_BLOCK;
                            p_grow = 1'b1;
                        end else begin
                            p_emit  = 1'b1;
                            p_kind  = ctbs_pkg::KIND_OTHER;
                            p_start = 1'b1;
                        end
                    end else begin
                        p_start = 1'b1;
                    end
                end
                ctbs_pkg::MODE_SPACE: begin
                    if (ctbs_pkg::is_ws(i_byte)) begin
                        p_grow = 1'b1;
                    end else begin
                        p_emit  = 1'b1;
                        p_kind  = ctbs_pkg::KIND_SPACE;
                        p_start = 1'b1;
                    end
                end
                ctbs_pkg::MODE_LINE: begin
                    if (i_byte == ctbs_pkg::CH_LF) begin
                        p_emit   = 1'b1;
                        p_kind   = ctbs_pkg::KIND_LINE;
                        p_closed = 1'b1;
                        p_start  = 1'b1;
                    end else begin
                        p_grow = 1'b1;
                    end
                end
                ctbs_pkg::MODE_BLOCK: begin
                    p_grow = 1'b1;
                    if (i_byte == ctbs_pkg::CH_STAR) begin
                        n_mode = ctbs_pkg::MODE_BLOCK_STAR;
                    end
                end
                ctbs_pkg::MODE_BLOCK_STAR: begin
                    p_grow = 1'b1;
                    if (i_byte == ctbs_pkg::CH_SLASH) begin
                        p_emit   = 1'b1;
                        p_kind   = ctbs_pkg::KIND_BLOCK;
                        p_closed = 1'b1;
                    end else if (i_byte != ctbs_pkg::CH_STAR) begin
                        n_mode = ctbs_pkg::MODE_BLOCK;
                    end
                end
                ctbs_pkg::MODE_PP: begin
                    if (i_byte == ctbs_pkg::CH_LF) begin
                        p_emit  = 1'b1;
                        p_kind  = ctbs_pkg::KIND_PP;
                        p_start = 1'b1;
                    end else begin
                        p_grow = 1'b1;
                        n_mode = (i_byte == ctbs_pkg::CH_BSLASH) ? ctbs_pkg::MODE_PP_BS
                                                                : ctbs_pkg::MODE_PP;
                    end
                end
                ctbs_pkg::MODE_PP_BS_CR: begin
                    p_grow = 1'b1;
                    n_mode = (i_byte == ctbs_pkg::CH_BSLASH) ? ctbs_pkg::MODE_PP_BS
                                                            : ctbs_pkg::MODE_PP;
                end
                ctbs_pkg::MODE_PP_BS: begin
                    p_grow = 1'b1;
                    if (i_byte == ctbs_pkg::CH_CR) begin
                        n_mode = ctbs_pkg::MODE_PP_BS_CR;
                    end else if (i_byte == ctbs_pkg::CH_BSLASH) begin
                        n_mode = ctbs_pkg::MODE_PP_BS;
                    end else begin
                        n_mode = ctbs_pkg::MODE_PP;
                    end
                end
                ctbs_pkg::MODE_RAW_DELIM: begin
                    if (i_byte == ctbs_pkg::CH_LPAREN) begin
                        p_grow = 1'b1;
                        n_mode = ctbs_pkg::MODE_RAW_BODY;
                    end else if (i_byte == ctbs_pkg::CH_LF ||
                                 r_dlen >= DLW'(MAX_DELIMITER)) begin
                        p_emit  = 1'b1;
                        p_kind  = ctbs_pkg::KIND_RAW;
                        p_start = 1'b1;
                    end else begin
                        wr_en  = 1'b1;
                        n_dlen = DLW'(r_dlen + 1'b1);
                        p_grow = 1'b1;
                    end
                end
                ctbs_pkg::MODE_RAW_BODY: begin
                    p_body = 1'b1;
                end
                ctbs_pkg::MODE_RAW_MATCH: begin
                    if (r_match < r_dlen) begin
                        if (i_byte == r_dlm_q) begin
                            p_grow  = 1'b1;
                            n_match = DLW'(r_match + 1'b1);
                        end else begin
                            p_body = 1'b1;
                        end
                    end else if (i_byte == ctbs_pkg::CH_DQUOTE) begin
                        p_grow   = 1'b1;
                        p_emit   = 1'b1;
                        p_kind   = ctbs_pkg::KIND_RAW;
                        p_closed = 1'b1;
                    end else begin
                        p_body = 1'b1;
                    end
                end
                ctbs_pkg::MODE_IDENT: begin
                    n_la = 1'b0;
                    if (r_la && i_byte == ctbs_pkg::CH_DQUOTE) begin
                        n_mode  = ctbs_pkg::MODE_RAW_DELIM;
                        n_dlen  = '0;
                        n_match = '0;
                        p_grow  = 1'b1;
                    end else if (ctbs_pkg::is_cont(i_byte)) begin
                        p_grow = 1'b1;
                    end else begin
                        p_emit  = 1'b1;
                        p_kind  = ctbs_pkg::KIND_IDENT;
                        p_start = 1'b1;
                    end
                end
                ctbs_pkg::MODE_NUMBER: begin
                    if (ctbs_pkg::is_cont(i_byte) || i_byte == ctbs_pkg::CH_DOT ||
                        i_byte == ctbs_pkg::CH_SQUOTE) begin
                        p_grow = 1'b1;
                    end else begin
                        p_emit  = 1'b1;
                        p_kind  = ctbs_pkg::KIND_NUMBER;
                        p_start = 1'b1;
                    end
                end
                ctbs_pkg::MODE_STRING, ctbs_pkg::MODE_CHAR: begin
                    p_kind = (r_mode == ctbs_pkg::MODE_STRING) ? ctbs_pkg::KIND_STRING
                                                              : ctbs_pkg::KIND_CHAR;
                    if (r_esc) begin
                        p_grow = 1'b1;
                        n_esc  = 1'b0;
                    end else if ((r_mode == ctbs_pkg::MODE_STRING &&
                                  i_byte == ctbs_pkg::CH_DQUOTE) ||
                                 (r_mode == ctbs_pkg::MODE_CHAR &&
                                  i_byte == ctbs_pkg::CH_SQUOTE)) begin
                        p_grow   = 1'b1;
                        p_emit   = 1'b1;
                        p_closed = 1'b1;
                    end else if (i_byte == ctbs_pkg::CH_LF) begin
                        p_emit  = 1'b1;
                        p_start = 1'b1;
                    end else begin
                        p_grow = 1'b1;
                        if (i_byte == ctbs_pkg::CH_BSLASH) begin
                            n_esc = 1'b1;
                        end
                    end
                end
                default: begin
                    n_mode  = ctbs_pkg::MODE_IDLE;
                    p_start = 1'b1;
                end
            endcase

            // raw string body byte, a close paren opens a delimiter match
            if (p_body) begin
                p_grow = 1'b1;
                if (i_byte == ctbs_pkg::CH_RPAREN) begin
                    n_mode  = ctbs_pkg::MODE_RAW_MATCH;
                    n_match = '0;
                end else begin
                    n_mode = ctbs_pkg::MODE_RAW_BODY;
                end
            end

            if (p_grow && n_len != '1) begin
                n_len = LENGTH_BITS'(n_len + 1'b1);
            end

            if (p_emit) begin
                n_res.tok[n_cnt[0]] = mk_tok(p_kind, n_len, p_closed);
                n_res.vld[n_cnt[0]] = 1'b1;
                n_cnt   = 2'(n_cnt + 1'b1);
                n_len   = '0;
                n_mode  = ctbs_pkg::MODE_IDLE;
                n_la    = 1'b0;
                n_esc   = 1'b0;
                n_match = '0;
            end

            // this byte opens the next token
            if (p_start) begin
                n_len = LENGTH_BITS'(1);
                n_esc = 1'b0;
                if (i_byte == ctbs_pkg::CH_HASH && r_als) begin
                    n_mode = ctbs_pkg::MODE_PP;
                end else if (i_byte == ctbs_pkg::CH_SLASH) begin
                    n_mode = ctbs_pkg::MODE_IDLE;
                    n_la   = 1'b1;
                end else if (i_byte == ctbs_pkg::CH_UPPER_R) begin
                    n_mode = ctbs_pkg::MODE_IDENT;
                    n_la   = 1'b1;
                end else if (ctbs_pkg::is_alpha(i_byte)) begin
                    n_mode = ctbs_pkg::MODE_IDENT;
                end else if (ctbs_pkg::is_digit(i_byte)) begin
                    n_mode = ctbs_pkg::MODE_NUMBER;
                end else if (i_byte == ctbs_pkg::CH_DQUOTE) begin
                    n_mode = ctbs_pkg::MODE_STRING;
                end else if (i_byte == ctbs_pkg::CH_SQUOTE) begin
                    n_mode = ctbs_pkg::MODE_CHAR;
                end else if (ctbs_pkg::is_ws(i_byte)) begin
                    n_mode = ctbs_pkg::MODE_SPACE;
                end else begin
                    n_res.tok[n_cnt[0]] = mk_tok(ctbs_pkg::KIND_OTHER, n_len, 1'b0);
                    n_res.vld[n_cnt[0]] = 1'b1;
                    n_cnt   = 2'(n_cnt + 1'b1);
                    n_len   = '0;
                    n_mode  = ctbs_pkg::MODE_IDLE;
                    n_la    = 1'b0;
                    n_match = '0;
                end
            end

            if (i_eot) begin
                f_emit = 1'b1;
                unique case (n_mode) inside
                    ctbs_pkg::MODE_IDLE: begin
                        f_emit = n_la;
                        f_kind = ctbs_pkg::KIND_OTHER;
                    end
                    ctbs_pkg::MODE_SPACE:  f_kind = ctbs_pkg::KIND_SPACE;
                    ctbs_pkg::MODE_LINE:   f_kind = ctbs_pkg::KIND_LINE;
                    ctbs_pkg::MODE_BLOCK, ctbs_pkg::MODE_BLOCK_STAR:
                        f_kind = ctbs_pkg::KIND_BLOCK;
                    ctbs_pkg::MODE_PP, ctbs_pkg::MODE_PP_BS, ctbs_pkg::MODE_PP_BS_CR:
                        f_kind = ctbs_pkg::KIND_PP;
                    ctbs_pkg::MODE_RAW_DELIM, ctbs_pkg::MODE_RAW_BODY,
                    ctbs_pkg::MODE_RAW_MATCH:
                        f_kind = ctbs_pkg::KIND_RAW;
                    ctbs_pkg::MODE_IDENT:  f_kind = ctbs_pkg::KIND_IDENT;
                    ctbs_pkg::MODE_NUMBER: f_kind = ctbs_pkg::KIND_NUMBER;
                    ctbs_pkg::MODE_STRING: f_kind = ctbs_pkg::KIND_STRING;
                    ctbs_pkg::MODE_CHAR:   f_kind = ctbs_pkg::KIND_CHAR;
                    default:               f_emit = 1'b0;
                endcase
                if (f_emit) begin
                    n_res.tok[n_cnt[0]] = mk_tok(f_kind, n_len, 1'b0);
                    n_res.vld[n_cnt[0]] = 1'b1;
                    n_cnt = 2'(n_cnt + 1'b1);
                end
                if (n_cnt != 2'd0) begin
                    n_res.tok[n_cnt[1]].final_token = 1'b1;
                end
                n_mode  = ctbs_pkg::MODE_IDLE;
                n_la    = 1'b0;
                n_len   = '0;
                n_esc   = 1'b0;
                n_match = '0;
                n_dlen  = '0;
                n_als   = 1'b1;
            end else begin
                n_als = (i_byte == ctbs_pkg::CH_LF);
            end
        end
    end

    assign o_res = n_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= ctbs_pkg::MODE_IDLE;
            r_la    <= 1'b0;
            r_len   <= '0;
            r_esc   <= 1'b0;
            r_match <= '0;
            r_dlen  <= '0;
            r_als   <= 1'b1;
        end else begin
            r_mode  <= n_mode;
            r_la    <= n_la;
            r_len   <= n_len;
            r_esc   <= n_esc;
            r_match <= n_match;
            r_dlen  <= n_dlen;
            r_als   <= n_als;
        end
    end

    // entry for the next compare is fetched as the match index moves
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_dlm[wr_addr] <= i_byte;
        end
        r_dlm_q <= r_dlm[n_match[AW-1:0]];
    end

    a_la_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_la |-> (r_mode == ctbs_pkg::MODE_IDLE || r_mode == ctbs_pkg::MODE_IDENT))
        else $error("held start byte outside idle or identifier");

    a_esc_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_esc |-> (r_mode == ctbs_pkg::MODE_STRING || r_mode == ctbs_pkg::MODE_CHAR))
        else $error("escape pending outside a quoted literal");

    a_dlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dlen <= DLW'(MAX_DELIMITER)) &&
        ((r_mode == ctbs_pkg::MODE_RAW_MATCH) -> (r_match <= r_dlen)))
        else $error("delimiter length or match index out of range");

    a_eot_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eot) |-> o_res.vld[0])
        else $error("end of text produced no token");

    a_eot_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_eot) |=> (r_mode == ctbs_pkg::MODE_IDLE && r_len == '0 && r_als))
        else $error("scan state not cleared after end of text");

endmodule

// ===== sv/ctbs_fifo.sv =====
module ctbs_fifo (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  ctbs_pkg::t_step_out            i_push,
    input  logic                           i_pop,
    output ctbs_pkg::t_token               o_head,
    output logic [ctbs_pkg::Q_CNT_W-1:0]   o_count
);

    localparam int PW = ctbs_pkg::Q_PTR_W;
    localparam int CW = ctbs_pkg::Q_CNT_W;

    ctbs_pkg::t_token   r_buf [ctbs_pkg::Q_DEPTH];
    logic [PW-1:0]      r_wr, r_rd;
    logic [CW-1:0]      r_count;
    logic [CW-1:0]      push_n;

    assign push_n = CW'(i_push.vld[0]) + CW'(i_push.vld[1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= PW'(r_wr + PW'(push_n));
            r_rd    <= PW'(r_rd + PW'(i_pop));
            r_count <= CW'(r_count + push_n - CW'(i_pop));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld[0]) begin
            r_buf[r_wr] <= i_push.tok[0];
        end
        if (i_push.vld[1]) begin
            r_buf[PW'(r_wr + PW'(1))] <= i_push.tok[1];
        end
    end

    assign o_head  = r_buf[r_rd];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.vld != 2'b00) |-> (r_count <= CW'(ctbs_pkg::Q_DEPTH - 2)))
        else $error("token queue pushed without room");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("token queue popped while empty");

    a_slot_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld[1] |-> i_push.vld[0])
        else $error("second slot pushed without the first");

endmodule

// ===== test/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ctbs_pkg::*;

    // predictor sizes, matching the block's default parameters
    localparam int DELIM_MAX = 16;
    localparam int LEN_CAP   = 65535;
    localparam int STEP_CAP  = 3;

    // run shape
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 16;
    localparam int LONG_FILL      = 65540;
    localparam int DIRECTED_ROWS  = 24;

    localparam logic [7:0] BLANKS     [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};
    localparam logic [7:0] BLOCK_FILL [4] = '{CH_STAR, CH_SLASH, CH_LOWER_A, CH_LF};

    // one row of the directed table; typed rows carry their token by hand
    typedef struct packed {
        logic [7:0] text_byte;
        logic       eot;
        logic       typed;
        t_token     tok;
    } stim_row;

    localparam t_token NO_TOKEN = '0;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_text_byte   = '0;
    logic        i_end_of_text = 1'b0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [15:0] o_token_length;
    logic        o_closed;
    logic        o_final_token;

    // hand-typed expectation travels with the byte beat
    logic   row_typed = 1'b0;
    t_token row_token = '0;

    // tokens still owed by the block, oldest first
    t_token pending_tokens [$];

    // scanner model state
    t_mode       scan_state;
    logic        held;
    int unsigned tok_len;
    logic [7:0]  delim_buf [DELIM_MAX];
    int          delim_len;
    int          match_pos;
    logic        escaped;
    logic        line_start;
    int          step_base;

    // stimulus control
    logic [7:0] text_bytes [$];
    logic       quiet   = 1'b0;
    logic       gaps_on = 1'b1;
    logic       stall_on = 1'b1;
    int         stall_left;
    int         idle_cycles;
    int         fail_count;

    // directed table: extremes, the awkward corners and every token kind but line comment, raw and number
    stim_row directed_rows [DIRECTED_ROWS] = '{
        // hash at text start opens a preprocessor line
        '{CH_HASH,    1'b1, 1'b1, '{KIND_PP,    16'd1, 1'b0, 1'b1}},
        // top and bottom byte values are single other tokens
        '{8'hFF,      1'b1, 1'b1, '{KIND_OTHER, 16'd1, 1'b0, 1'b1}},
        '{8'h00,      1'b1, 1'b1, '{KIND_OTHER, 16'd1, 1'b0, 1'b1}},
        // blank, hash not first on its line, lone slash, lone R, escape on last byte
        '{CH_SPACE,   1'b0, 1'b0, NO_TOKEN},
        '{CH_HASH,    1'b0, 1'b0, NO_TOKEN},
        '{CH_SLASH,   1'b0, 1'b0, NO_TOKEN},
        '{CH_UPPER_R, 1'b0, 1'b0, NO_TOKEN},
        '{"x",        1'b0, 1'b0, NO_TOKEN},
        '{CH_DQUOTE,  1'b0, 1'b0, NO_TOKEN},
        '{CH_BSLASH,  1'b1, 1'b0, NO_TOKEN},
        // the star of the opener cannot close the comment
        '{CH_SLASH,   1'b0, 1'b0, NO_TOKEN},
        '{CH_STAR,    1'b0, 1'b0, NO_TOKEN},
        '{CH_SLASH,   1'b0, 1'b0, NO_TOKEN},
        '{CH_STAR,    1'b0, 1'b0, NO_TOKEN},
        '{CH_SLASH,   1'b1, 1'b1, '{KIND_BLOCK, 16'd5, 1'b1, 1'b1}},
        // newline cuts a char literal short
        '{CH_SQUOTE,  1'b0, 1'b0, NO_TOKEN},
        '{CH_LOWER_A, 1'b0, 1'b0, NO_TOKEN},
        '{CH_LF,      1'b1, 1'b0, NO_TOKEN},
        // backslash CR LF continues a preprocessor line
        '{CH_HASH,    1'b0, 1'b0, NO_TOKEN},
        '{CH_BSLASH,  1'b0, 1'b0, NO_TOKEN},
        '{CH_CR,      1'b0, 1'b0, NO_TOKEN},
        '{CH_LF,      1'b0, 1'b0, NO_TOKEN},
        '{"x",        1'b0, 1'b0, NO_TOKEN},
        '{CH_LF,      1'b1, 1'b0, NO_TOKEN}
    };

    c_token_boundary_scanner_core dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_text_byte    (i_text_byte),
        .i_end_of_text  (i_end_of_text),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_token_kind   (o_token_kind),
        .o_token_length (o_token_length),
        .o_closed       (o_closed),
        .o_final_token  (o_final_token)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // scanner model
    // ------------------------------------------------------------------

    function automatic logic is_letter_ch(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
    endfunction

    function automatic logic is_digit_ch(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_word_ch(logic [7:0] c);
        return is_letter_ch(c) || is_digit_ch(c);
    endfunction

    function automatic logic is_blank_ch(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    // length saturates instead of wrapping
    function automatic void bump_len();
        if (tok_len < LEN_CAP) tok_len++;
    endfunction

    // report the open token and go back to idle
    function automatic void close_token(t_kind kind, logic closed_flag);
        t_token t;
        if (pending_tokens.size() - step_base < STEP_CAP) begin
            t.kind        = kind;
            t.length      = tok_len[15:0];
            t.closed      = closed_flag;
            t.final_token = 1'b0;
            pending_tokens.push_back(t);
        end
        tok_len    = 0;
        scan_state = MODE_IDLE;
        held       = 1'b0;
        escaped    = 1'b0;
        match_pos  = 0;
    endfunction

    // first byte of a token picks its kind; slash and R wait for one more byte
    function automatic void open_token(logic [7:0] b);
        tok_len = 1;
        escaped = 1'b0;
        if (b == CH_HASH && line_start) scan_state = MODE_PP;
        else if (b == CH_SLASH) begin
            scan_state = MODE_IDLE;
            held       = 1'b1;
        end else if (b == CH_UPPER_R) begin
            scan_state = MODE_IDENT;
            held       = 1'b1;
        end else if (is_letter_ch(b)) scan_state = MODE_IDENT;
        else if (is_digit_ch(b)) scan_state = MODE_NUMBER;
        else if (b == CH_DQUOTE) scan_state = MODE_STRING;
        else if (b == CH_SQUOTE) scan_state = MODE_CHAR;
        else if (is_blank_ch(b)) scan_state = MODE_SPACE;
        else close_token(KIND_OTHER, 1'b0);
    endfunction

    function automatic void raw_body_byte(logic [7:0] b);
        scan_state = MODE_RAW_BODY;
        bump_len();
        if (b == CH_RPAREN) begin
            scan_state = MODE_RAW_MATCH;
            match_pos  = 0;
        end
    endfunction

    function automatic void quoted_byte(logic [7:0] b, logic [7:0] q, t_kind kind);
        if (escaped) begin
            bump_len();
            escaped = 1'b0;
        end else if (b == q) begin
            bump_len();
            close_token(kind, 1'b1);
        end else if (b == CH_LF) begin
            close_token(kind, 1'b0);
            open_token(b);
        end else begin
            bump_len();
            if (b == CH_BSLASH) escaped = 1'b1;
        end
    endfunction

    function automatic void tokenize_byte(logic [7:0] b);
        case (scan_state)
            MODE_IDLE: begin
                if (held) begin
                    held = 1'b0;
                    if (b == CH_SLASH) begin
                        scan_state = MODE_LINE;
                        bump_len();
                    end else if (b == CH_STAR) begin
                        scan_state = MODE_BLOCK;
                        bump_len();
                    end else begin
                        close_token(KIND_OTHER, 1'b0);
                        open_token(b);
                    end
                end else begin
                    open_token(b);
                end
            end
            MODE_SPACE: begin
                if (is_blank_ch(b)) bump_len();
                else begin
                    close_token(KIND_SPACE, 1'b0);
                    open_token(b);
                end
            end
            MODE_LINE: begin
                if (b == CH_LF) begin
                    close_token(KIND_LINE, 1'b1);
                    open_token(b);
                end else bump_len();
            end
            MODE_BLOCK: begin
                bump_len();
                if (b == CH_STAR) scan_state = MODE_BLOCK_STAR;
            end
            MODE_BLOCK_STAR: begin
                bump_len();
                if (b == CH_SLASH) close_token(KIND_BLOCK, 1'b1);
                else if (b != CH_STAR) scan_state = MODE_BLOCK;
            end
            MODE_PP, MODE_PP_BS_CR: begin
                if (b == CH_LF && scan_state == MODE_PP) begin
                    close_token(KIND_PP, 1'b0);
                    open_token(b);
                end else begin
                    bump_len();
                    scan_state = (b == CH_BSLASH) ? MODE_PP_BS : MODE_PP;
                end
            end
            MODE_PP_BS: begin
                bump_len();
                if (b == CH_CR) scan_state = MODE_PP_BS_CR;
                else if (b == CH_BSLASH) scan_state = MODE_PP_BS;
                else scan_state = MODE_PP;
            end
            MODE_RAW_DELIM: begin
                if (b == CH_LPAREN) begin
                    bump_len();
                    scan_state = MODE_RAW_BODY;
                end else if (b == CH_LF || delim_len >= DELIM_MAX) begin
                    close_token(KIND_RAW, 1'b0);
                    open_token(b);
                end else begin
                    delim_buf[delim_len] = b;
                    delim_len++;
                    bump_len();
                end
            end
            MODE_RAW_BODY: raw_body_byte(b);
            MODE_RAW_MATCH: begin
                if (match_pos < delim_len && match_pos < DELIM_MAX) begin
                    if (b == delim_buf[match_pos]) begin
                        bump_len();
                        match_pos++;
                    end else raw_body_byte(b);
                end else if (b == CH_DQUOTE) begin
                    bump_len();
                    close_token(KIND_RAW, 1'b1);
                end else raw_body_byte(b);
            end
            MODE_IDENT: begin
                if (held && b == CH_DQUOTE) begin
                    held       = 1'b0;
                    scan_state = MODE_RAW_DELIM;
                    delim_len  = 0;
                    match_pos  = 0;
                    bump_len();
                end else begin
                    held = 1'b0;
                    if (is_word_ch(b)) bump_len();
                    else begin
                        close_token(KIND_IDENT, 1'b0);
                        open_token(b);
                    end
                end
            end
            MODE_NUMBER: begin
                if (is_word_ch(b) || b == CH_DOT || b == CH_SQUOTE) bump_len();
                else begin
                    close_token(KIND_NUMBER, 1'b0);
                    open_token(b);
                end
            end
            MODE_STRING: quoted_byte(b, CH_DQUOTE, KIND_STRING);
            MODE_CHAR:   quoted_byte(b, CH_SQUOTE, KIND_CHAR);
            default: begin
                scan_state = MODE_IDLE;
                open_token(b);
            end
        endcase
    endfunction

    // end of text reports whatever is still open
    function automatic void flush_text();
        case (scan_state)
            MODE_IDLE:        if (held) close_token(KIND_OTHER, 1'b0);
            MODE_SPACE:       close_token(KIND_SPACE, 1'b0);
            MODE_LINE:        close_token(KIND_LINE, 1'b0);
            MODE_BLOCK, MODE_BLOCK_STAR:
                close_token(KIND_BLOCK, 1'b0);
            MODE_PP, MODE_PP_BS, MODE_PP_BS_CR:
                close_token(KIND_PP, 1'b0);
            MODE_RAW_DELIM, MODE_RAW_BODY, MODE_RAW_MATCH:
                close_token(KIND_RAW, 1'b0);
            MODE_IDENT:       close_token(KIND_IDENT, 1'b0);
            MODE_NUMBER:      close_token(KIND_NUMBER, 1'b0);
            MODE_STRING:      close_token(KIND_STRING, 1'b0);
            MODE_CHAR:        close_token(KIND_CHAR, 1'b0);
            default: ;
        endcase
    endfunction

    function automatic void clear_scanner();
        scan_state = MODE_IDLE;
        held       = 1'b0;
        tok_len    = 0;
        foreach (delim_buf[i]) delim_buf[i] = '0;
        delim_len  = 0;
        match_pos  = 0;
        escaped    = 1'b0;
        line_start = 1'b1;
    endfunction

    // one accepted byte: queue the tokens it finishes
    function automatic void accept_byte(logic [7:0] b, logic eot);
        step_base = pending_tokens.size();
        tokenize_byte(b);
        if (eot) begin
            flush_text();
            clear_scanner();
            if (pending_tokens.size() > step_base)
                pending_tokens[pending_tokens.size() - 1].final_token = 1'b1;
        end else begin
            line_start = (b == CH_LF);
        end
    endfunction

    // ------------------------------------------------------------------
    // random text fragments
    // ------------------------------------------------------------------

    function automatic logic [7:0] word_byte();
        case ($urandom_range(0, 3))
            0:       return CH_LOWER_A + $urandom_range(0, 25);
            1:       return CH_UPPER_A + $urandom_range(0, 25);
            2:       return CH_DIGIT_0 + $urandom_range(0, 9);
            default: return CH_UNDERSCORE;
        endcase
    endfunction

    // mostly well-formed tokens with random content, plus noise
    function automatic void add_fragment();
        int         pick;
        int         n;
        int         m;
        logic [7:0] c;
        logic [7:0] q;
        logic [7:0] delim [$];
        pick = $urandom_range(0, 11);
        case (pick)
            0: begin
                n = $urandom_range(1, 4);
                repeat (n) text_bytes.push_back(BLANKS[$urandom_range(0, 3)]);
            end
            1: begin
                // R start can turn into a raw string if a quote follows
                text_bytes.push_back(($urandom_range(0, 3) == 0) ? CH_UPPER_R :
                                     CH_LOWER_A + $urandom_range(0, 25));
                n = $urandom_range(0, 6);
                repeat (n) text_bytes.push_back(word_byte());
            end
            2: begin
                text_bytes.push_back(CH_DIGIT_0 + $urandom_range(0, 9));
                n = $urandom_range(0, 5);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0)
                        text_bytes.push_back($urandom_range(0, 1) ? CH_DOT : CH_SQUOTE);
                    else
                        text_bytes.push_back(word_byte());
                end
            end
            3, 4: begin
                q = (pick == 3) ? CH_DQUOTE : CH_SQUOTE;
                text_bytes.push_back(q);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    if ($urandom_range(0, 4) == 0) begin
                        text_bytes.push_back(CH_BSLASH);
                        text_bytes.push_back($urandom_range(0, 255));
                    end else begin
                        text_bytes.push_back($urandom_range(8'h20, 8'h7e));
                    end
                end
                case ($urandom_range(0, 7))
                    0:       text_bytes.push_back(CH_LF);
                    1:       ;
                    default: text_bytes.push_back(q);
                endcase
            end
            5: begin
                text_bytes.push_back(CH_SLASH);
                text_bytes.push_back(CH_SLASH);
                n = $urandom_range(0, 8);
                repeat (n) begin
                    do c = $urandom_range(0, 255); while (c == CH_LF);
                    text_bytes.push_back(c);
                end
                if ($urandom_range(0, 7) != 0) text_bytes.push_back(CH_LF);
            end
            6: begin
                text_bytes.push_back(CH_SLASH);
                text_bytes.push_back(CH_STAR);
                n = $urandom_range(0, 8);
                repeat (n) text_bytes.push_back(BLOCK_FILL[$urandom_range(0, 3)]);
                if ($urandom_range(0, 7) != 0) begin
                    text_bytes.push_back(CH_STAR);
                    text_bytes.push_back(CH_SLASH);
                end
            end
            7: begin
                // directive on a fresh line, with continuations
                text_bytes.push_back(CH_LF);
                text_bytes.push_back(CH_HASH);
                n = $urandom_range(1, 8);
                repeat (n) begin
                    case ($urandom_range(0, 5))
                        0: begin
                            text_bytes.push_back(CH_BSLASH);
                            text_bytes.push_back(CH_LF);
                        end
                        1: begin
                            text_bytes.push_back(CH_BSLASH);
                            text_bytes.push_back(CH_CR);
                            text_bytes.push_back(CH_LF);
                        end
                        2: text_bytes.push_back(CH_BSLASH);
                        default: text_bytes.push_back($urandom_range(8'h20, 8'h7e));
                    endcase
                end
                text_bytes.push_back(CH_LF);
            end
            8: begin
                // raw string, sometimes with a delimiter past the store size
                text_bytes.push_back(CH_UPPER_R);
                text_bytes.push_back(CH_DQUOTE);
                n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
                repeat (n) begin
                    do c = $urandom_range(8'h21, 8'h7e); while (c == CH_LPAREN);
                    delim.push_back(c);
                    text_bytes.push_back(c);
                end
                text_bytes.push_back(CH_LPAREN);
                n = $urandom_range(0, 5);
                repeat (n) text_bytes.push_back($urandom_range(8'h20, 8'h7e));
                if ($urandom_range(0, 1) == 1) begin
                    // close that breaks off partway, possibly on another paren
                    text_bytes.push_back(CH_RPAREN);
                    m = $urandom_range(0, delim.size());
                    for (int i = 0; i < m; i++) text_bytes.push_back(delim[i]);
                    text_bytes.push_back($urandom_range(0, 1) ? CH_RPAREN : "z");
                end
                case ($urandom_range(0, 5))
                    0: ;
                    1: text_bytes.push_back(CH_LF);
                    default: begin
                        text_bytes.push_back(CH_RPAREN);
                        foreach (delim[i]) text_bytes.push_back(delim[i]);
                        text_bytes.push_back(CH_DQUOTE);
                    end
                endcase
            end
            9: begin
                n = $urandom_range(1, 3);
                repeat (n) text_bytes.push_back($urandom_range(0, 255));
            end
            10: begin
                text_bytes.push_back(CH_SLASH);
                text_bytes.push_back($urandom_range(0, 255));
            end
            default: begin
                text_bytes.push_back($urandom_range(0, 1) ? CH_HASH : $urandom_range(8'h21, 8'h2f));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // byte channel driver
    // ------------------------------------------------------------------

    // hold the beat until the block takes it, with an optional gap before it
    task automatic send_byte(input logic [7:0] b, input logic eot, input logic typed,
                             input t_token tok);
        if (!quiet && gaps_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_text_byte   <= b;
        i_end_of_text <= eot;
        row_typed     <= typed;
        row_token     <= tok;
        do @(posedge i_clk); while (o_stall);
    endtask

    // let the output side run dry with the input held off
    task automatic drain_tokens();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_tokens.size() != 0);
    endtask

    // whole random texts until the byte budget is spent
    task automatic run_texts(input int budget);
        int done;
        int texts;
        done  = 0;
        texts = 0;
        while (done < budget) begin
            text_bytes.delete();
            repeat ($urandom_range(3, 8)) add_fragment();
            gaps_on = ($urandom_range(0, 2) != 0);
            foreach (text_bytes[i])
                send_byte(text_bytes[i], i == text_bytes.size() - 1, 1'b0, NO_TOKEN);
            done += text_bytes.size();
            texts++;
            if (texts == 2 || $urandom_range(0, 9) == 0) drain_tokens();
        end
    endtask

    initial begin
        clear_scanner();
        fail_count  = 0;
        stall_left  = 0;
        idle_cycles = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[r])
            send_byte(directed_rows[r].text_byte, directed_rows[r].eot,
                      directed_rows[r].typed, directed_rows[r].tok);

        run_texts(350);

        // one comment long enough to saturate the length count
        gaps_on = 1'b0;
        send_byte(CH_SLASH, 1'b0, 1'b0, NO_TOKEN);
        send_byte(CH_SLASH, 1'b0, 1'b0, NO_TOKEN);
        repeat (LONG_FILL) send_byte(CH_LOWER_A, 1'b0, 1'b0, NO_TOKEN);
        send_byte(CH_LF, 1'b1, 1'b0, NO_TOKEN);

        // closing stretch at full rate on both sides
        quiet = 1'b1;
        run_texts(100);

        drain_tokens();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_tokens.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // token checker, byte predictor, output stall and watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        t_token want;
        logic   moved;
        if (!i_rst_n) begin
            clear_scanner();
            i_stall    <= 1'b0;
            stall_left  = 0;
            idle_cycles = 0;
        end else begin
            moved = 1'b0;

            // token beat: compare with the oldest expectation
            if (o_valid && !i_stall) begin
                moved = 1'b1;
                if (pending_tokens.size() == 0) begin
                    $error("token with nothing expected: kind %0d length %0d",
                           o_token_kind, o_token_length);
                    fail_count++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (o_token_kind !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind, o_token_kind);
                        fail_count++;
                    end
                    if (o_token_length !== want.length) begin
                        $error("token_length: expected %0d, got %0d",
                               want.length, o_token_length);
                        fail_count++;
                    end
                    if (o_closed !== want.closed) begin
                        $error("closed: expected %0d, got %0d", want.closed, o_closed);
                        fail_count++;
                    end
                    if (o_final_token !== want.final_token) begin
                        $error("final_token: expected %0d, got %0d",
                               want.final_token, o_final_token);
                        fail_count++;
                    end
                end
            end

            // byte beat: predict, or take the hand-typed token for this row
            if (i_valid && !o_stall) begin
                moved = 1'b1;
                accept_byte(i_text_byte, i_end_of_text);
                if (row_typed) begin
                    while (pending_tokens.size() > step_base) void'(pending_tokens.pop_back());
                    pending_tokens.push_back(row_token);
                end
            end

            // stall bursts, switched on and off in stretches
            if ($urandom_range(0, 99) == 0) stall_on = !stall_on;
            if (stall_left != 0) begin
                stall_left--;
                i_stall <= 1'b1;
            end else if (!quiet && stall_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 17);
                i_stall   <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end

            // no beat on either side for too long means the block is hung
            if (moved) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

endmodule
